[hdl/mmh_pkg.sv]
package mmh_pkg;

  // Default sizing
  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 32;

  // Operation codes on the func port
  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_POP_MIN = 2'd1,
    FN_POP_MAX = 2'd2,
    FN_NOP     = 2'd3
  } func_t;

  // Status codes on the status port
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP_MIN,
    CMD_POP_MAX
  } cmd_t;

  // Occupancy of one cell: none, one key, or a lo/hi pair
  typedef enum logic [1:0] {
    OCC_EMPTY,
    OCC_HALF,
    OCC_FULL
  } occ_t;

  // What a cell tells its downstream neighbor
  typedef struct packed {
    occ_t occ;
    logic lt;   // insert key below this cell's lo
    logic gt;   // insert key above this cell's hi
  } link_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REPORT
  } state_t;

endpackage

[hdl/min_max_heap_top.sv]
// Double-ended priority queue. Keys are held as a row of (CAPACITY+1)/2
// cells, each keeping a lo/hi pair so that cell 0 always shows the smallest
// and largest stored key. A transaction is taken when start is high and busy
// is low. Busy is high for the one cycle in which every cell updates in
// parallel from its neighbors; in the next cycle done pulses for exactly one
// cycle with removed_key, min_key, max_key, count and status. The receiver
// cannot stall the result: it must take it in that cycle. A new transaction
// may be started in the done cycle, so the block takes a new item while it
// reports the last one, though not while the cells update, at any fill level.
// Insert into a full queue and removal from an empty one change nothing and
// report status full or empty; func code 3 only reports the current state.
module min_max_heap_top #(
  parameter int CAPACITY  = mmh_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mmh_pkg::DEF_KEY_WIDTH,
  localparam int CNT_WIDTH = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func,
  input  logic signed [KEY_WIDTH-1:0] key,
  output logic                        done,
  output logic signed [KEY_WIDTH-1:0] removed_key,
  output logic signed [KEY_WIDTH-1:0] min_key,
  output logic signed [KEY_WIDTH-1:0] max_key,
  output logic [CNT_WIDTH-1:0]        count,
  output logic [1:0]                  status
);

  localparam int NCELL = (CAPACITY + 1) / 2;

  mmh_pkg::state_t             state;
  mmh_pkg::state_t             state_next;
  mmh_pkg::func_t              op_func;
  logic signed [KEY_WIDTH-1:0] op_key;
  mmh_pkg::cmd_t               cmd;
  logic signed [KEY_WIDTH-1:0] head_lo;
  logic signed [KEY_WIDTH-1:0] head_hi;
  logic signed [KEY_WIDTH-1:0] removed_key_next;
  logic [1:0]                  status_next;
  logic [CNT_WIDTH-1:0]        count_next;
  logic                        accept;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmh_pkg::S_IDLE:   if (start) state_next = mmh_pkg::S_EXEC;
      mmh_pkg::S_EXEC:   state_next = mmh_pkg::S_REPORT;
      mmh_pkg::S_REPORT: state_next = start ? mmh_pkg::S_EXEC : mmh_pkg::S_IDLE;
      default:           state_next = mmh_pkg::S_IDLE;
    endcase
  end

  // Outputs and command decode
  always_comb begin
    busy             = (state == mmh_pkg::S_EXEC);
    done             = (state == mmh_pkg::S_REPORT);
    cmd              = mmh_pkg::CMD_HOLD;
    removed_key_next = removed_key;
    status_next      = status;
    count_next       = count;
    if (state == mmh_pkg::S_EXEC) begin
      removed_key_next = '0;
      status_next      = mmh_pkg::ST_DONE;
      unique case (op_func)
        mmh_pkg::FN_INSERT: begin
          if (count == CNT_WIDTH'(CAPACITY)) begin
            status_next = mmh_pkg::ST_FULL;
          end else begin
            cmd        = mmh_pkg::CMD_INSERT;
            count_next = count + CNT_WIDTH'(1);
          end
        end
        mmh_pkg::FN_POP_MIN: begin
          if (count == '0) begin
            status_next = mmh_pkg::ST_EMPTY;
          end else begin
            cmd              = mmh_pkg::CMD_POP_MIN;
            removed_key_next = head_lo;
            count_next       = count - CNT_WIDTH'(1);
          end
        end
        mmh_pkg::FN_POP_MAX: begin
          if (count == '0) begin
            status_next = mmh_pkg::ST_EMPTY;
          end else begin
            cmd              = mmh_pkg::CMD_POP_MAX;
            removed_key_next = head_hi;
            count_next       = count - CNT_WIDTH'(1);
          end
        end
        mmh_pkg::FN_NOP: ;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmh_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Transaction capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func <= mmh_pkg::func_t'(func);
      op_key  <= key;
    end
    removed_key <= removed_key_next;
    status      <= status_next;
  end

  // Extremes come straight from cell 0, or are zero when the queue is empty
  assign min_key = (count == '0) ? '0 : head_lo;
  assign max_key = (count == '0) ? '0 : head_hi;

  mmh_chain #(
    .KEY_WIDTH(KEY_WIDTH),
    .NCELL    (NCELL)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ins_key(op_key),
    .head_lo(head_lo),
    .head_hi(head_hi)
  );

endmodule

[hdl/mmh_cell.sv]
// One cell of the nested-interval row. Cell i holds the i-th smallest key
// (lo) and the i-th largest key (hi); the innermost occupied cell may hold
// a single key, kept in both lo and hi.
module mmh_cell #(
  parameter int KEY_WIDTH = mmh_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mmh_pkg::cmd_t               cmd,
  input  logic signed [KEY_WIDTH-1:0] ins_key,
  input  mmh_pkg::link_t              prev_link,
  input  logic signed [KEY_WIDTH-1:0] prev_lo,
  input  logic signed [KEY_WIDTH-1:0] prev_hi,
  input  mmh_pkg::occ_t               next_occ,
  input  logic signed [KEY_WIDTH-1:0] next_lo,
  input  logic signed [KEY_WIDTH-1:0] next_hi,
  output mmh_pkg::link_t              link,
  output logic signed [KEY_WIDTH-1:0] lo,
  output logic signed [KEY_WIDTH-1:0] hi
);

  mmh_pkg::occ_t               occ;
  mmh_pkg::occ_t               occ_next;
  logic signed [KEY_WIDTH-1:0] lo_next;
  logic signed [KEY_WIDTH-1:0] hi_next;
  logic signed [KEY_WIDTH-1:0] v_in;
  logic                        lt;
  logic                        gt;

  // Where the insert key falls against this interval
  assign lt = (occ == mmh_pkg::OCC_FULL) && (ins_key < lo);
  assign gt = (occ == mmh_pkg::OCC_FULL) && (ins_key > hi);
  assign link = '{occ: occ, lt: lt, gt: gt};

  // Key handed in by the upstream cell during an insert
  assign v_in = prev_link.lt ? prev_lo : (prev_link.gt ? prev_hi : ins_key);

  // Cell update
  always_comb begin
    occ_next = occ;
    lo_next  = lo;
    hi_next  = hi;
    unique case (cmd)
      mmh_pkg::CMD_INSERT: begin
        unique case (occ)
          mmh_pkg::OCC_FULL: begin
            if (lt) begin
              lo_next = v_in;
            end else if (gt) begin
              hi_next = v_in;
            end
          end
          mmh_pkg::OCC_HALF: begin
            occ_next = mmh_pkg::OCC_FULL;
            if (v_in < lo) begin
              lo_next = v_in;
            end else begin
              hi_next = v_in;
            end
          end
          mmh_pkg::OCC_EMPTY: begin
            // first empty cell behind a full one takes the overflow
            if (prev_link.occ == mmh_pkg::OCC_FULL) begin
              occ_next = mmh_pkg::OCC_HALF;
              lo_next  = v_in;
              hi_next  = v_in;
            end
          end
          default: ;
        endcase
      end
      mmh_pkg::CMD_POP_MIN: begin
        if (occ == mmh_pkg::OCC_FULL) begin
          if (next_occ == mmh_pkg::OCC_EMPTY) begin
            occ_next = mmh_pkg::OCC_HALF;
            lo_next  = hi;
          end else begin
            lo_next = next_lo;
          end
        end else if (occ == mmh_pkg::OCC_HALF) begin
          occ_next = mmh_pkg::OCC_EMPTY;
        end
      end
      mmh_pkg::CMD_POP_MAX: begin
        if (occ == mmh_pkg::OCC_FULL) begin
          if (next_occ == mmh_pkg::OCC_EMPTY) begin
            occ_next = mmh_pkg::OCC_HALF;
            hi_next  = lo;
          end else begin
            hi_next = next_hi;
          end
        end else if (occ == mmh_pkg::OCC_HALF) begin
          occ_next = mmh_pkg::OCC_EMPTY;
        end
      end
      mmh_pkg::CMD_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= mmh_pkg::OCC_EMPTY;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
  end

endmodule

[hdl/mmh_chain.sv]
// Row of cells; cell 0 always holds the global minimum and maximum.
module mmh_chain #(
  parameter int KEY_WIDTH = mmh_pkg::DEF_KEY_WIDTH,
  parameter int NCELL     = mmh_pkg::DEF_CAPACITY / 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mmh_pkg::cmd_t               cmd,
  input  logic signed [KEY_WIDTH-1:0] ins_key,
  output logic signed [KEY_WIDTH-1:0] head_lo,
  output logic signed [KEY_WIDTH-1:0] head_hi
);

  mmh_pkg::link_t              links [NCELL];
  logic signed [KEY_WIDTH-1:0] los   [NCELL];
  logic signed [KEY_WIDTH-1:0] his   [NCELL];

  assign head_lo = los[0];
  assign head_hi = his[0];

  genvar i;
  for (i = 0; i < NCELL; i++) begin : g_cell
    mmh_pkg::link_t              pl;
    logic signed [KEY_WIDTH-1:0] pl_lo;
    logic signed [KEY_WIDTH-1:0] pl_hi;
    mmh_pkg::occ_t               nx_occ;
    logic signed [KEY_WIDTH-1:0] nx_lo;
    logic signed [KEY_WIDTH-1:0] nx_hi;

    // Cell 0 sees a virtual full neighbor that passes the key straight in
    if (i == 0) begin : g_head
      assign pl    = '{occ: mmh_pkg::OCC_FULL, lt: 1'b0, gt: 1'b0};
      assign pl_lo = '0;
      assign pl_hi = '0;
    end else begin : g_body
      assign pl    = links[i-1];
      assign pl_lo = los[i-1];
      assign pl_hi = his[i-1];
    end

    // Last cell sees a virtual empty neighbor
    if (i == NCELL - 1) begin : g_tail
      assign nx_occ = mmh_pkg::OCC_EMPTY;
      assign nx_lo  = '0;
      assign nx_hi  = '0;
    end else begin : g_inner
      assign nx_occ = links[i+1].occ;
      assign nx_lo  = los[i+1];
      assign nx_hi  = his[i+1];
    end

    mmh_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .ins_key  (ins_key),
      .prev_link(pl),
      .prev_lo  (pl_lo),
      .prev_hi  (pl_hi),
      .next_occ (nx_occ),
      .next_lo  (nx_lo),
      .next_hi  (nx_hi),
      .link     (links[i]),
      .lo       (los[i]),
      .hi       (his[i])
    );
  end

endmodule

[hdl/mmh_checker.sv]
// Port-level checks for the queue
module mmh_checker #(
  parameter int KEY_WIDTH = mmh_pkg::DEF_KEY_WIDTH,
  parameter int CNT_WIDTH = $clog2(mmh_pkg::DEF_CAPACITY + 1)
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic signed [KEY_WIDTH-1:0] min_key,
  input logic signed [KEY_WIDTH-1:0] max_key,
  input logic [CNT_WIDTH-1:0]        count,
  input logic [1:0]                  status
);

  // A taken transaction keeps the block busy for the update cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // The update cycle is always followed by the result cycle
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("no result after update cycle");

  // Empty queue reports zero extremes; refused removal only when empty
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (count == '0)) |-> ((min_key == '0) && (max_key == '0)))
    else $error("empty queue reports nonzero extremes");

  a_refuse_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == mmh_pkg::ST_EMPTY)) |-> (count == '0))
    else $error("removal refused while keys are stored");

  // Ordering of the extremes
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (done && (count != '0)) |-> (min_key <= max_key))
    else $error("minimum above maximum");

endmodule

bind min_max_heap_top mmh_checker #(
  .KEY_WIDTH(KEY_WIDTH),
  .CNT_WIDTH(CNT_WIDTH)
) u_mmh_checker (.*);
